// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the RTL controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is held low.
`define PMS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, also evaluated during reset.
`define PMS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/pms_pkg.sv -----
`timescale 1ns / 1ps

package pms_pkg;

  localparam int MEM_DEPTH_DEF       = 64;
  localparam int STACK_COUNT_MAX_DEF = 8;

  localparam int DATA_W       = 32;
  localparam int CNT_W        = 7;
  localparam int ID_W         = 3;
  localparam int CMD_W        = 2;
  localparam int ST_W         = 2;
  localparam int NSTK_W       = 4;
  localparam int IDX_W        = 6;
  localparam int RESULT_LIMIT = 64;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 7;
  localparam int IN_DATA_W    = 40;
  localparam int OUT_USER_W   = 4;

  // commands
  localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DISPLAY = 2'd3;

  // result status
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD_ID = 2'd3;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STACKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_SIZE = 1'd1;

  // controller -> datapath
  typedef struct packed {
    logic            latch;
    logic            push_wr;
    logic            pop_dec;
    logic            disp_start;
    logic            disp_next;
    logic            out_load;
    logic            out_mem;
    logic            flags_zero;
    logic            out_last;
    logic [ST_W-1:0] status;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic             bad;
    logic [CMD_W-1:0] cmd;
    logic             cnt_zero;
    logic             is_full;
    logic             disp_last;
  } dp_stat_t;

endpackage

// ----- rtl/partitioned_multi_stack.sv -----
// Partitioned multi-stack: one single-port memory of MEM_DEPTH 32-bit words split into
// num_stacks equal partitions, each a LIFO stack. A request names a stack and a command:
// push, pop, query flags, or display contents (bottom to top, tlast on the final entry).
// Full push, empty pop and ids at or beyond the stack count come back with a status; every
// result but a bad id's carries the stack's full/empty flags after the command. Any config
// write clears all fill counts; write config only while no request is in flight. One request
// is handled at a time: push, query and refused commands pass through accept and execute,
// pop adds a wait state (the memory read is registered), and display streams its N entries
// after execute, one entry per cycle while out_tready is high. These steps come from the
// controller's accept/execute sequence and the registered memory read port. A new request
// is accepted while the last result still waits in the output register.
`timescale 1ns / 1ps

module partitioned_multi_stack #(
  parameter int MEM_DEPTH       = pms_pkg::MEM_DEPTH_DEF,
  parameter int STACK_COUNT_MAX = pms_pkg::STACK_COUNT_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // config write port
  input  logic                               cfg_we,
  input  logic [pms_pkg::CFG_IDX_W-1:0]      cfg_index,   // 0 num_stacks, 1 stack_size
  input  logic [pms_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // request stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [pms_pkg::IN_DATA_W-1:0]      in_tdata,    // [2:0] stack_id, [34:3] push_value
  input  logic [pms_pkg::CMD_W-1:0]          in_tuser,    // [1:0] command
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [pms_pkg::DATA_W-1:0]         out_tdata,   // [31:0] data
  output logic [pms_pkg::OUT_USER_W-1:0]     out_tuser,   // [1:0] status, [2] is_full,
                                                          // [3] is_empty
  output logic                               out_tlast
);
  import pms_pkg::*;

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [ST_W-1:0]   out_status;
  logic              out_full;
  logic              out_empty;

  // sequencer: accept, execute, then pop wait or display streaming
  pms_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // config, fill counts, stack memory, output payload
  pms_datapath #(
    .MEM_DEPTH       (MEM_DEPTH),
    .STACK_COUNT_MAX (STACK_COUNT_MAX)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_cmd     (in_tuser),
    .in_id      (in_tdata[ID_W-1:0]),
    .in_value   (in_tdata[ID_W+DATA_W-1:ID_W]),
    .cmd        (cmd),
    .stat       (stat),
    .out_status (out_status),
    .out_data   (out_tdata),
    .out_full   (out_full),
    .out_empty  (out_empty),
    .out_last   (out_tlast)
  );

  assign out_tuser = {out_empty, out_full, out_status};

endmodule

// ----- rtl/pms_datapath.sv -----
`timescale 1ns / 1ps

module pms_datapath #(
  parameter int MEM_DEPTH       = pms_pkg::MEM_DEPTH_DEF,
  parameter int STACK_COUNT_MAX = pms_pkg::STACK_COUNT_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pms_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [pms_pkg::CMD_W-1:0]          in_cmd,
  input  logic [pms_pkg::ID_W-1:0]           in_id,
  input  logic [pms_pkg::DATA_W-1:0]         in_value,
  input  pms_pkg::dp_cmd_t                   cmd,
  output pms_pkg::dp_stat_t                  stat,
  output logic [pms_pkg::ST_W-1:0]           out_status,
  output logic [pms_pkg::DATA_W-1:0]         out_data,
  output logic                               out_full,
  output logic                               out_empty,
  output logic                               out_last
);
  import pms_pkg::*;

  localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // config registers
  logic [NSTK_W-1:0] num_stacks_r;
  logic [CNT_W-1:0]  stack_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_stacks_r <= NSTK_W'(1);
      stack_size_r <= CNT_W'(RESULT_LIMIT);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_STACKS: num_stacks_r <= cfg_wdata[NSTK_W-1:0];
        CFG_STACK_SIZE: stack_size_r <= cfg_wdata[CNT_W-1:0];
      endcase
    end
  end

  // partition size per stack count, worked out at elaboration
  logic [CNT_W-1:0] cap_tab [16];
  for (genvar g = 0; g < 16; g++) begin : g_cap
    localparam int CAP_RAW = (g == 0 || g > STACK_COUNT_MAX) ? 0 :
                             MEM_DEPTH / ((g == 0) ? 1 : g);
    localparam int CAP = (CAP_RAW > RESULT_LIMIT) ? RESULT_LIMIT : CAP_RAW;
    assign cap_tab[g] = CNT_W'(CAP);
  end

  logic [NSTK_W-1:0] n_eff;
  logic [CNT_W-1:0]  cap;
  logic [CNT_W-1:0]  size;

  always_comb begin
    if ({1'b0, num_stacks_r} > 5'(STACK_COUNT_MAX)) n_eff = NSTK_W'(STACK_COUNT_MAX);
    else                                           n_eff = num_stacks_r;
    cap  = cap_tab[n_eff];
    size = (stack_size_r < cap) ? stack_size_r : cap;
  end

  // latched request
  logic [CMD_W-1:0]  cmd_r;
  logic [ID_W-1:0]   id_r;
  logic [DATA_W-1:0] val_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r <= in_cmd;
      id_r  <= in_id;
      val_r <= in_value;
    end
  end

  // fill counts
  logic [CNT_W-1:0] fill_r [STACK_COUNT_MAX];
  logic [CNT_W-1:0] cnt_raw;
  logic [CNT_W-1:0] cnt;

  always_comb begin
    cnt_raw = '0;
    for (int g = 0; g < STACK_COUNT_MAX; g++) begin
      if (5'(id_r) == 5'(g)) cnt_raw = fill_r[g];
    end
    cnt = (cnt_raw > size) ? size : cnt_raw;
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < STACK_COUNT_MAX; g++) begin
      if (!rst_n || cfg_we) begin
        fill_r[g] <= '0;
      end else if (5'(id_r) == 5'(g)) begin
        if (cmd.push_wr)      fill_r[g] <= cnt + CNT_W'(1);
        else if (cmd.pop_dec) fill_r[g] <= cnt - CNT_W'(1);
      end
    end
  end

  // address: partition base plus slot offset
  logic [IDX_W-1:0] idx_r;
  logic [9:0]       base;
  logic [CNT_W-1:0] offset;
  logic [10:0]      addr_sum;
  logic [AW-1:0]    mem_addr;
  logic             rd_en;

  always_comb begin
    base = 10'(id_r) * 10'(size);
    if (cmd.pop_dec)         offset = cnt - CNT_W'(1);
    else if (cmd.disp_start) offset = '0;
    else if (cmd.disp_next)  offset = CNT_W'(idx_r) + CNT_W'(1);
    else                     offset = cnt;
    addr_sum = 11'(base) + 11'(offset);
    mem_addr = addr_sum[AW-1:0];
    rd_en    = cmd.pop_dec | cmd.disp_start | cmd.disp_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.disp_start)     idx_r <= '0;
    else if (cmd.disp_next) idx_r <= idx_r + IDX_W'(1);
  end

  // stack memory
  logic [DATA_W-1:0] mem [MEM_DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.push_wr) mem[mem_addr] <= val_r;
    if (rd_en)       rdata_r <= mem[mem_addr];
  end

  // output payload
  logic [ST_W-1:0]   out_status_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_full_r;
  logic              out_empty_r;
  logic              out_last_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.status;
      out_data_r   <= cmd.out_mem ? rdata_r : '0;
      out_last_r   <= cmd.out_last;
      if (cmd.flags_zero) begin
        out_full_r  <= 1'b0;
        out_empty_r <= 1'b0;
      end else if (cmd.push_wr) begin
        out_full_r  <= ({1'b0, cnt} + 8'd1) >= {1'b0, size};
        out_empty_r <= 1'b0;
      end else begin
        out_full_r  <= cnt >= size;
        out_empty_r <= cnt == '0;
      end
    end
  end

  assign stat.bad       = ({1'b0, id_r} >= n_eff) || (5'(id_r) >= 5'(STACK_COUNT_MAX));
  assign stat.cmd       = cmd_r;
  assign stat.cnt_zero  = cnt == '0;
  assign stat.is_full   = cnt >= size;
  assign stat.disp_last = (CNT_W'(idx_r) + CNT_W'(1)) == cnt;

  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_full   = out_full_r;
  assign out_empty  = out_empty_r;
  assign out_last   = out_last_r;

endmodule

// ----- rtl/pms_ctrl.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pms_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  pms_pkg::dp_stat_t stat,
  output pms_pkg::dp_cmd_t  cmd
);
  import pms_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_POPW = 2'd2;
  localparam logic [1:0] S_DISP = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = state_r == S_IDLE;

  always_comb begin
    cmd       = '0;
    cmd.latch = in_tvalid && in_tready;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
          if (stat.bad) begin
            cmd.out_load   = 1'b1;
            cmd.flags_zero = 1'b1;
            cmd.status     = ST_BAD_ID;
          end else begin
            unique case (stat.cmd)
              CMD_PUSH: begin
                cmd.out_load = 1'b1;
                cmd.push_wr  = !stat.is_full;
                cmd.status   = stat.is_full ? ST_FULL : ST_OK;
              end
              CMD_POP: begin
                if (stat.cnt_zero) begin
                  cmd.out_load = 1'b1;
                  cmd.status   = ST_EMPTY;
                end else begin
                  cmd.pop_dec = 1'b1;
                  state_nxt   = S_POPW;
                end
              end
              CMD_QUERY: begin
                cmd.out_load = 1'b1;
                cmd.status   = ST_OK;
              end
              CMD_DISPLAY: begin
                if (stat.cnt_zero) begin
                  cmd.out_load = 1'b1;
                  cmd.status   = ST_EMPTY;
                end else begin
                  cmd.disp_start = 1'b1;
                  state_nxt      = S_DISP;
                end
              end
            endcase
          end
        end
      end
      S_POPW: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_mem  = 1'b1;
          cmd.out_last = 1'b1;
          cmd.status   = ST_OK;
          state_nxt    = S_IDLE;
        end
      end
      S_DISP: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_mem  = 1'b1;
          cmd.out_last = stat.disp_last;
          cmd.status   = ST_OK;
          if (stat.disp_last) state_nxt = S_IDLE;
          else                cmd.disp_next = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load)    out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `PMS_ASSERT(a_accept_to_exec, clk, rst_n, (in_tvalid && in_tready) |=> (state_r == S_EXEC), "accepted request did not reach execute")
  `PMS_ASSERT(a_valid_from_load, clk, rst_n, $rose(out_valid_r) |-> $past(cmd.out_load), "result valid rose without a load")
  `PMS_ASSERT(a_last_ends_item, clk, rst_n, (cmd.out_load && cmd.out_last) |=> (state_r == S_IDLE), "final result did not end the request")
  `PMS_ASSERT_ALWAYS(a_one_mem_op, clk, !(cmd.push_wr && (cmd.pop_dec || cmd.disp_start || cmd.disp_next)), "write and read issued together")

endmodule

// ----- dv/pms_checker.sv -----
`timescale 1ns / 1ps

module pms_checker #(
  parameter int MEM_DEPTH       = pms_pkg::MEM_DEPTH_DEF,
  parameter int STACK_COUNT_MAX = pms_pkg::STACK_COUNT_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pms_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [pms_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [pms_pkg::CMD_W-1:0]      in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [pms_pkg::DATA_W-1:0]     out_tdata,
  input  logic [pms_pkg::OUT_USER_W-1:0] out_tuser,
  input  logic                           out_tlast,
  output int                             fail_count,
  output int                             pending_results
);
  import pms_pkg::*;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] data;
    logic              is_full;
    logic              is_empty;
    logic              last;
  } stack_result_t;

  logic [DATA_W-1:0]     slot_word [MEM_DEPTH];
  logic [CNT_W-1:0]      fill_count [STACK_COUNT_MAX];
  logic [NSTK_W-1:0]     num_stacks_reg;
  logic [CFG_DATA_W-1:0] stack_size_reg;
  stack_result_t         awaited_results [$];
  int                    errors = 0;

  function automatic int unsigned live_stacks();
    return (num_stacks_reg > STACK_COUNT_MAX) ? STACK_COUNT_MAX : num_stacks_reg;
  endfunction

  // Partition size after clamping to the memory and to one display's worth.
  function automatic int unsigned slots_per_stack();
    int unsigned n;
    int unsigned s;
    n = live_stacks();
    if (n == 0) return 0;
    s = stack_size_reg;
    if (s > MEM_DEPTH / n) s = MEM_DEPTH / n;
    if (s > RESULT_LIMIT) s = RESULT_LIMIT;
    return s;
  endfunction

  function automatic stack_result_t make_result(logic [ST_W-1:0] status,
                                                logic [DATA_W-1:0] data,
                                                logic full, logic empty, logic last);
    stack_result_t r;
    r.status   = status;
    r.data     = data;
    r.is_full  = full;
    r.is_empty = empty;
    r.last     = last;
    return r;
  endfunction

  task automatic apply_stack_request(input logic [CMD_W-1:0] cmd,
                                     input logic [ID_W-1:0] id,
                                     input logic [DATA_W-1:0] value);
    int unsigned size;
    int unsigned base;
    int unsigned cnt;
    int unsigned addr;
    size = slots_per_stack();
    if (id >= live_stacks()) begin
      awaited_results.push_back(make_result(ST_BAD_ID, '0, 1'b0, 1'b0, 1'b1));
      return;
    end
    base = id * size;
    cnt  = fill_count[id];
    if (cnt > size) cnt = size;
    case (cmd)
      CMD_PUSH: begin
        if (cnt >= size) begin
          awaited_results.push_back(make_result(ST_FULL, '0, 1'b1, cnt == 0, 1'b1));
        end else begin
          addr = base + cnt;
          if (addr < MEM_DEPTH) slot_word[addr] = value;
          cnt++;
          fill_count[id] = CNT_W'(cnt);
          awaited_results.push_back(make_result(ST_OK, '0, cnt >= size, 1'b0, 1'b1));
        end
      end
      CMD_POP: begin
        if (cnt == 0) begin
          awaited_results.push_back(make_result(ST_EMPTY, '0, size == 0, 1'b1, 1'b1));
        end else begin
          cnt--;
          addr = base + cnt;
          fill_count[id] = CNT_W'(cnt);
          awaited_results.push_back(make_result(ST_OK, (addr < MEM_DEPTH) ? slot_word[addr] : '0,
                                                1'b0, cnt == 0, 1'b1));
        end
      end
      CMD_QUERY: begin
        awaited_results.push_back(make_result(ST_OK, '0, cnt >= size, cnt == 0, 1'b1));
      end
      default: begin
        if (cnt == 0) begin
          awaited_results.push_back(make_result(ST_EMPTY, '0, size == 0, 1'b1, 1'b1));
        end else begin
          for (int i = 0; i < cnt && i < RESULT_LIMIT; i++) begin
            addr = base + i;
            awaited_results.push_back(make_result(ST_OK,
                                                  (addr < MEM_DEPTH) ? slot_word[addr] : '0,
                                                  cnt >= size, 1'b0, i + 1 == cnt));
          end
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    stack_result_t want;
    if (!rst_n) begin
      foreach (fill_count[i]) fill_count[i] = '0;
      num_stacks_reg = 1;
      stack_size_reg = 64;
      awaited_results.delete();
    end else begin
      // results first: a request accepted on this edge cannot have produced one yet
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $error("result with nothing outstanding: data 0x%0h user 0x%0h last %0b",
                 out_tdata, out_tuser, out_tlast);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", DATA_W'(want.status), DATA_W'(out_tuser[1:0]));
          check_field("data", want.data, out_tdata);
          check_field("is_full", DATA_W'(want.is_full), DATA_W'(out_tuser[2]));
          check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(out_tuser[3]));
          check_field("last", DATA_W'(want.last), DATA_W'(out_tlast));
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_NUM_STACKS) num_stacks_reg = cfg_wdata[NSTK_W-1:0];
        else stack_size_reg = cfg_wdata;
        foreach (fill_count[i]) fill_count[i] = '0;
      end
      if (in_tvalid && in_tready)
        apply_stack_request(in_tuser, in_tdata[ID_W-1:0], in_tdata[ID_W +: DATA_W]);
    end
    pending_results <= awaited_results.size();
    fail_count      <= errors;
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import pms_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 8;
  localparam int LONG_STALL   = 200;         // receiver hold-off, in cycles
  localparam int SETTLE       = 4;           // idle cycles before a config write
  localparam int END_WAIT     = 20;          // wait after the last drain, catches stray results
  localparam int RUN_LIMIT_NS = 10_000_000;  // far beyond the slowest run
  localparam int PAD_W        = IN_DATA_W - ID_W - DATA_W;

  typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_RHYTHM} ready_mode_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = CFG_NUM_STACKS;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // [2:0] stack_id, [34:3] push_value
  logic [CMD_W-1:0]      in_tuser   = CMD_QUERY;  // [1:0] command
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [DATA_W-1:0]     out_tdata;         // [31:0] data
  logic [OUT_USER_W-1:0] out_tuser;         // [1:0] status, [2] is_full, [3] is_empty
  logic                  out_tlast;

  int fail_count;
  int pending_results;
  int stall_requests = 0;   // bumped by stimulus, consumed by the receiver

  // stimulus-side view of the current partitioning, used only to shape sequences
  int stacks_live;
  int slots_live;
  int burst_left;
  bit no_gaps;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  partitioned_multi_stack dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  pms_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // Result side: ready follows a randomly chosen pattern for a random stretch,
  // or holds ready low for a long stall, sized by LONG_STALL, when stimulus asks for it.
  initial begin : receiver
    int          stalls_done;
    int          mode_left;
    int          beat;
    ready_mode_t mode;
    stalls_done = 0;
    mode_left   = 0;
    beat        = 0;
    mode        = RDY_ALWAYS;
    forever begin
      @(posedge clk);
      if (stall_requests != stalls_done) begin
        stalls_done++;
        out_tready <= 1'b0;
        repeat (LONG_STALL - 1) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = ready_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        beat++;
        case (mode)
          RDY_ALWAYS: out_tready <= 1'b1;
          RDY_COIN:   out_tready <= 1'($urandom_range(0, 1));
          RDY_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
          default:    out_tready <= (beat % 4 != 3);
        endcase
      end
    end
  end

  // One request: hold it until accepted. Bursts end in a random gap unless
  // no_gaps is set; consecutive requests in a burst keep tvalid high.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                              input logic [DATA_W-1:0] value);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{PAD_W{1'b0}}, value, id};
    do @(posedge clk); while (!in_tready);
    if (!no_gaps) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_tvalid <= 1'b0;
        if ($urandom_range(0, 7) == 0) repeat ($urandom_range(20, 40)) @(posedge clk);
        else repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  // Sender pauses until every outstanding result is back, then lets the block settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes both registers back to back; either write clears all fill counts.
  task automatic configure(input int nstk, input int size);
    int n;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NUM_STACKS;
    cfg_wdata <= CFG_DATA_W'(nstk);
    @(posedge clk);
    cfg_index <= CFG_STACK_SIZE;
    cfg_wdata <= CFG_DATA_W'(size);
    @(posedge clk);
    cfg_we <= 1'b0;
    n = (nstk > STACK_COUNT_MAX_DEF) ? STACK_COUNT_MAX_DEF : nstk;
    stacks_live = n;
    if (n == 0) slots_live = 0;
    else slots_live = (size < MEM_DEPTH_DEF / n) ? size : MEM_DEPTH_DEF / n;
  endtask

  // Fill a stack (possibly past full), dump it, then pop (possibly past empty).
  task automatic stack_workout(input int id, input int pushes, input int pops);
    repeat (pushes) send_request(CMD_PUSH, ID_W'(id), $urandom());
    send_request(CMD_DISPLAY, ID_W'(id), $urandom());
    repeat (pops) send_request(CMD_POP, ID_W'(id), $urandom());
    send_request($urandom_range(0, 1) ? CMD_QUERY : CMD_DISPLAY, ID_W'(id), $urandom());
  endtask

  // Mostly well-formed push/display/pop runs on live stacks, some raw noise
  // (any command, any id, bad ids included). Run length tracks the quota left.
  task automatic random_phase(input int quota);
    int sent;
    int id;
    int pushes;
    int pops;
    int room;
    int pmax;
    sent = 0;
    while (sent < quota) begin
      if (stacks_live == 0 || $urandom_range(0, 3) == 0) begin
        send_request(CMD_W'($urandom_range(0, 3)), ID_W'($urandom_range(0, 7)), $urandom());
        sent++;
      end else begin
        room = (quota - sent) / 2;
        if (room < 1) room = 1;
        pmax = slots_live + 1;
        if (pmax > room) pmax = room;
        id     = $urandom_range(0, stacks_live - 1);
        pushes = $urandom_range(1, pmax);
        pops   = $urandom_range(0, pushes + 1);
        stack_workout(id, pushes, pops);
        sent += pushes + pops + 2;
      end
    end
  endtask

  initial begin : stimulus
    stacks_live = 1;
    slots_live  = 64;
    burst_left  = 4;
    no_gaps     = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, reset config: one stack of 64 slots ---
    send_request(CMD_QUERY, 0, 32'h0);           // empty flags
    send_request(CMD_POP, 0, 32'hFFFF_FFFF);     // pop on empty stack refused
    send_request(CMD_DISPLAY, 0, 32'h0);         // display of an empty stack
    send_request(CMD_PUSH, 1, 32'h1234_5678);    // id beyond stack count
    send_request(CMD_POP, 7, 32'h0);
    send_request(CMD_QUERY, 4, 32'h0);
    send_request(CMD_DISPLAY, 7, 32'h0);
    send_request(CMD_PUSH, 0, 32'h8000_0000);    // most negative
    send_request(CMD_PUSH, 0, 32'h7FFF_FFFF);    // most positive
    send_request(CMD_PUSH, 0, 32'hFFFF_FFFF);
    send_request(CMD_PUSH, 0, 32'h0);
    send_request(CMD_PUSH, 0, 32'hA5A5_A5A5);
    send_request(CMD_DISPLAY, 0, 32'h0);
    send_request(CMD_POP, 0, 32'h0);
    send_request(CMD_QUERY, 0, 32'h0);

    // --- directed, eight stacks of three: full stack and push refusal ---
    drain();
    configure(8, 3);
    send_request(CMD_PUSH, 7, 32'h5A5A_5A5A);
    send_request(CMD_PUSH, 7, 32'h0000_0001);
    send_request(CMD_PUSH, 7, 32'hFFFF_FFFE);
    send_request(CMD_PUSH, 7, 32'hDEAD_BEEF);    // push on full stack refused
    send_request(CMD_QUERY, 7, 32'h0);
    send_request(CMD_DISPLAY, 7, 32'h0);
    send_request(CMD_POP, 7, 32'h0);
    send_request(CMD_POP, 7, 32'h0);
    send_request(CMD_POP, 7, 32'h0);
    send_request(CMD_POP, 7, 32'h0);

    // --- one stack of 64: the receiver holds off, so the block backs up and stalls its
    //     input; then fill to full and dump all 64 ---
    drain();
    configure(1, 64);
    stall_requests <= stall_requests + 1;
    no_gaps = 1'b1;
    stack_workout(0, 65, 6);
    no_gaps = 1'b0;
    random_phase(8);
    drain();                                     // sender waits for every result
    random_phase(6);

    // --- further partitionings, extremes included ---
    drain();
    configure(2, 5);
    random_phase(6);
    drain();
    configure(4, 127);                           // size clamps to 16
    random_phase(6);
    drain();
    configure(12, 2);                            // count above max acts as 8
    random_phase(6);
    drain();
    configure(0, 5);                             // no stacks: every id is bad
    random_phase(4);
    drain();
    configure(3, 0);                             // size zero: full and empty at once
    random_phase(4);
    drain();
    configure(15, 1);
    random_phase(6);
    drain();
    configure(8, 8);
    random_phase(6);

    drain();
    repeat (END_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("** partitioned_multi_stack: PASSED **");
    end else begin
      $display("** partitioned_multi_stack: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #RUN_LIMIT_NS;
    $display("** partitioned_multi_stack: FAILED **");
    $finish;
  end

endmodule
